// ===== hw/rtl/sasp_pkg.sv =====
package sasp_pkg;

	// fixed field widths
	localparam int SA_W      = 32;
	localparam int LEN_W     = 17;
	localparam int CNT_W     = 16;
	localparam int QUOT_W    = 32;
	localparam int BBITS_W   = 5;
	localparam int OBITS_W   = 6;
	localparam int OFFSET_W  = 22;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	// build-time limits of the packed record
	localparam int POS_BITS   = 32;
	localparam int BLOCK_BITS = 16;

	// quotient width cap: smaller of POS_BITS and the quotient port
	localparam int OBITS_CAP = (POS_BITS < QUOT_W) ? POS_BITS : QUOT_W;

	// block length arithmetic runs at this width so the saturation point fits
	localparam int LEN_EXT_W = (BLOCK_BITS + 1 > LEN_W) ? BLOCK_BITS + 1 : LEN_W;

	// radix-2 divider: one quotient bit per step
	localparam int DIV_STEPS = SA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// register indexes
	localparam logic [0:0] REG_INTERVAL = 1'b0;
	localparam logic [0:0] REG_OBITS    = 1'b1;

	localparam logic [SA_W-1:0]    INTERVAL_RST = SA_W'(1);
	localparam logic [OBITS_W-1:0] OBITS_RST    = OBITS_W'(32);

	typedef struct packed {
		logic load;    // capture a new word and clear the divider
		logic step;    // one divider iteration
		logic commit;  // write the result register and advance block state
	} cmd_t;

	// significant bits of v, at least one
	function automatic logic [BBITS_W-1:0] sig_bits(input logic [LEN_EXT_W-1:0] v);
		logic [BBITS_W-1:0] n;
		n = BBITS_W'(1);
		for (int i = 0; i < LEN_EXT_W; i++) begin
			if (v[i]) begin
				n = BBITS_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/sasp_ctrl.sv =====
module sasp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output sasp_pkg::cmd_t cmd
);
	import sasp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.step   = (state_q == ST_BUSY);
		cmd.commit = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a new word always starts the divider from its first step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_BUSY) && (cnt_q == '0))
		else $error("accepted word did not start the divider");

	// the result register is never overwritten while it still holds a word
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit over an unread result");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	// divider does not finish before it has run its full step count
	a_steps_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) && (cnt_q != DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_q == ST_BUSY))
		else $error("divider left early");

endmodule

// ===== hw/rtl/sasp_dp.sv =====
module sasp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sasp_pkg::cmd_t                  cmd,
	input  logic [sasp_pkg::SA_W-1:0]       sa_value,
	input  logic [sasp_pkg::LEN_W-1:0]      block_len,
	input  logic [sasp_pkg::SA_W-1:0]       sample_interval,
	input  logic [sasp_pkg::OBITS_W-1:0]    orig_pos_bits,
	output logic                            sampled,
	output logic [sasp_pkg::CNT_W-1:0]      bwt_pos,
	output logic [sasp_pkg::QUOT_W-1:0]     orig_pos,
	output logic [sasp_pkg::BBITS_W-1:0]    bwt_pos_bits,
	output logic [sasp_pkg::OFFSET_W-1:0]   pair_bit_offset,
	output logic                            block_end
);
	import sasp_pkg::*;

	localparam logic [LEN_EXT_W-1:0] MAX_LEN = LEN_EXT_W'(1) << BLOCK_BITS;

	// block state
	logic [CNT_W-1:0]    entry_counter_q;
	logic [OFFSET_W-1:0] bits_written_q;

	// per-word working registers
	logic [SA_W-1:0]      quot_q;
	logic [SA_W-1:0]      rem_q;
	logic [LEN_EXT_W-1:0] len_m1_q;
	logic [BBITS_W-1:0]   bbits_q;

	// result register
	logic                sampled_q;
	logic [CNT_W-1:0]    bwt_pos_q;
	logic [QUOT_W-1:0]   orig_pos_q;
	logic [BBITS_W-1:0]  bwt_pos_bits_q;
	logic [OFFSET_W-1:0] pair_bit_offset_q;
	logic                block_end_q;

	logic [LEN_EXT_W-1:0] len_ext;
	logic [LEN_EXT_W-1:0] len_c;
	logic [LEN_EXT_W-1:0] len_m1;
	logic [OBITS_W-1:0]   obits;
	logic [SA_W:0]        shifted;
	logic [SA_W:0]        diff;
	logic                 samp;
	logic                 last;
	logic [QUOT_W-1:0]    mask;

	// clamp block length to 1 .. 2^BLOCK_BITS
	always_comb begin
		len_ext = LEN_EXT_W'(block_len);
		len_c   = len_ext;
		if (len_ext == '0) begin
			len_c = LEN_EXT_W'(1);
		end else if (len_ext > MAX_LEN) begin
			len_c = MAX_LEN;
		end
		len_m1 = len_c - LEN_EXT_W'(1);
	end

	assign obits = (orig_pos_bits > OBITS_W'(OBITS_CAP)) ? OBITS_W'(OBITS_CAP) : orig_pos_bits;

	// restoring divider step
	assign shifted = {rem_q, quot_q[SA_W-1]};
	assign diff    = shifted - {1'b0, sample_interval};

	assign samp = (sample_interval != '0) && (rem_q == '0);
	assign last = (LEN_EXT_W'(entry_counter_q) >= len_m1_q);
	assign mask = QUOT_W'(((QUOT_W+1)'(1) << obits) - (QUOT_W+1)'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q   <= sa_value;
			rem_q    <= '0;
			len_m1_q <= len_m1;
			bbits_q  <= sig_bits(len_m1);
		end else if (cmd.step) begin
			if (!diff[SA_W]) begin
				rem_q  <= diff[SA_W-1:0];
				quot_q <= {quot_q[SA_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[SA_W-1:0];
				quot_q <= {quot_q[SA_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			sampled_q         <= samp;
			bwt_pos_q         <= entry_counter_q;
			orig_pos_q        <= samp ? (QUOT_W'(quot_q) & mask) : '0;
			bwt_pos_bits_q    <= bbits_q;
			pair_bit_offset_q <= bits_written_q;
			block_end_q       <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_counter_q <= '0;
			bits_written_q  <= '0;
		end else if (cmd.commit) begin
			if (last) begin
				entry_counter_q <= '0;
				bits_written_q  <= '0;
			end else begin
				entry_counter_q <= entry_counter_q + 1'b1;
				if (samp) begin
					bits_written_q <= bits_written_q + OFFSET_W'(bbits_q) + OFFSET_W'(obits);
				end
			end
		end
	end

	assign sampled         = sampled_q;
	assign bwt_pos         = bwt_pos_q;
	assign orig_pos        = orig_pos_q;
	assign bwt_pos_bits    = bwt_pos_bits_q;
	assign pair_bit_offset = pair_bit_offset_q;
	assign block_end       = block_end_q;

endmodule

// ===== hw/rtl/suffix_array_sample_packer.sv =====
// the 32-step radix-2 divider (one quotient bit a cycle) sits between a
// capture step and a commit step; a new word is taken only once the
// previous one has been committed, and a finished result waits in an
// output register while the next word is taken
// reset (arst_n low, asynchronous): controller idle, block position and bit
// offset cleared, interval back to 1 and quotient width back to 32
module suffix_array_sample_packer (
	input  logic                                clk,
	input  logic                                arst_n,

	// apb configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sasp_pkg::APB_AW-1:0]         paddr,
	input  logic [sasp_pkg::APB_DW-1:0]         pwdata,
	output logic [sasp_pkg::APB_DW-1:0]         prdata,
	output logic                                pready,

	// input words
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sasp_pkg::SA_W-1:0]           sa_value,
	input  logic [sasp_pkg::LEN_W-1:0]          block_len,

	// result words
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sampled,
	output logic [sasp_pkg::CNT_W-1:0]          bwt_pos,
	output logic [sasp_pkg::QUOT_W-1:0]         orig_pos,
	output logic [sasp_pkg::BBITS_W-1:0]        bwt_pos_bits,
	output logic [sasp_pkg::OFFSET_W-1:0]       pair_bit_offset,
	output logic                                block_end
);
	import sasp_pkg::*;

	logic [SA_W-1:0]    sample_interval_q;
	logic [OBITS_W-1:0] orig_pos_bits_q;
	logic               cfg_wr;
	logic [0:0]         reg_idx;
	cmd_t               cmd;

	// registers sit 4 bytes apart; low address bits are ignored
	assign reg_idx = paddr[2:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	// registers must be written only while no word is in flight; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_interval_q <= INTERVAL_RST;
			orig_pos_bits_q   <= OBITS_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INTERVAL: sample_interval_q <= pwdata[SA_W-1:0];
				REG_OBITS:    orig_pos_bits_q   <= pwdata[OBITS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read-back
	always_comb begin
		case (reg_idx)
			REG_INTERVAL: prdata = APB_DW'(sample_interval_q);
			REG_OBITS:    prdata = APB_DW'(orig_pos_bits_q);
			default:      prdata = '0;
		endcase
	end

	// sequencer: capture, divide, commit
	sasp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// divider, block position / bit offset tracking and result register
	sasp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sa_value        (sa_value),
		.block_len       (block_len),
		.sample_interval (sample_interval_q),
		.orig_pos_bits   (orig_pos_bits_q),
		.sampled         (sampled),
		.bwt_pos         (bwt_pos),
		.orig_pos        (orig_pos),
		.bwt_pos_bits    (bwt_pos_bits),
		.pair_bit_offset (pair_bit_offset),
		.block_end       (block_end)
	);

endmodule
